@@ rtl/core/tvs_pkg.sv @@
package tvs_pkg;

  localparam int VOX_W    = 24;
  localparam int FRAC_W   = 16;
  localparam int WGT_W    = FRAC_W + 1;
  localparam int ACC_W    = 44;
  localparam int NCORNER  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [WGT_W-1:0] Q_ONE = WGT_W'(1) << FRAC_W;
  localparam logic signed [VOX_W-1:0] VOX_MAX = {1'b0, {(VOX_W-1){1'b1}}};
  localparam logic signed [VOX_W-1:0] VOX_MIN = {1'b1, {(VOX_W-1){1'b0}}};

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAC_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAC_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAC_Z = 3'd5;

  // command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic [5:0]              vox_x;
    logic [5:0]              vox_y;
    logic [4:0]              vox_z;
    logic signed [VOX_W-1:0] voxel_value;
    logic [5:0]              out_col;
    logic [5:0]              out_row;
  } in_item_t;

  typedef struct packed {
    logic signed [VOX_W-1:0] sample_value;
    logic                    out_of_volume;
  } out_item_t;

  // sample control that travels with the bank read data
  typedef struct packed {
    logic               valid;
    logic [NCORNER-1:0] oob;
    logic [2:0]         par;
  } smp_ctl_t;

  // q1.16 product rounded to 16 fraction bits
  function automatic logic [WGT_W-1:0] mul_round(input logic [WGT_W-1:0] a,
                                                 input logic [WGT_W-1:0] b);
    logic [2*WGT_W-1:0] p;
    p = (2*WGT_W)'(a) * (2*WGT_W)'(b) + (2*WGT_W)'(32768);
    return p[FRAC_W +: WGT_W];
  endfunction

endpackage

@@ rtl/core/trilinear_volume_slice_sampler.sv @@
// trilinear volume slice sampler
// channels:
//   command: start/busy with one in_item beat; accepted when start is high
//     and busy is low. cmd write stores voxel_value at (vox_x, vox_y, vox_z),
//     cmd sample blends the eight voxels around (base_x + out_col,
//     base_y + out_row, base_z) with the corner weights
//   result: out_valid strobes one out_item beat per sample, none per write;
//     there is no back pressure, the receiver takes every beat
//   config: cfg_valid/cfg_ready write of register cfg_index with cfg_data
// throughput: one command per cycle, writes and samples mixed freely; the
//   volume sits in eight parity banks (x, y, z parity) so all eight
//   neighbors of a sample are read from distinct banks in the same cycle
// pipeline: a sample's result is registered through the steps
//   (bank read, corner select, multiply, half sums, sum/shift/saturate)
// after a frac register write the weights rebuild through wxy_r, then weights_r
// reset: busy is high during reset, base and frac clear, corner 000 weighs
//   one; volume contents are undefined until written, no clearing pass
module trilinear_volume_slice_sampler
  import tvs_pkg::*;
#(
  parameter int DIM_X = 64,
  parameter int DIM_Y = 64,
  parameter int DIM_Z = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // each bank holds the voxels of one parity class
  localparam int HX = (DIM_X + 1) / 2;
  localparam int HY = (DIM_Y + 1) / 2;
  localparam int HZ = (DIM_Z + 1) / 2;
  localparam int BANK_DEPTH = HX * HY * HZ;
  localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  function automatic logic [AW-1:0] bank_addr(input int hx, input int hy, input int hz);
    return AW'((hx * HY + hy) * HZ + hz);
  endfunction

  // configuration registers
  logic [5:0]        base_x_r, base_y_r;
  logic [4:0]        base_z_r;
  logic [FRAC_W-1:0] frac_x_r, frac_y_r, frac_z_r;
  logic              busy_r;
  logic              cfg_wr;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign busy      = busy_r;
  assign accept    = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      base_x_r <= '0;
      base_y_r <= '0;
      base_z_r <= '0;
      frac_x_r <= '0;
      frac_y_r <= '0;
      frac_z_r <= '0;
    end else begin
      busy_r <= 1'b0;
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_BASE_X: base_x_r <= cfg_data[5:0];
          CFG_BASE_Y: base_y_r <= cfg_data[5:0];
          CFG_BASE_Z: base_z_r <= cfg_data[4:0];
          CFG_FRAC_X: frac_x_r <= cfg_data[FRAC_W-1:0];
          CFG_FRAC_Y: frac_y_r <= cfg_data[FRAC_W-1:0];
          CFG_FRAC_Z: frac_z_r <= cfg_data[FRAC_W-1:0];
          default: ;  // indexes past the list are dropped
        endcase
      end
    end
  end

  // corner weights, two-stage rebuild from the frac registers
  logic [NCORNER-1:0][WGT_W-1:0] weights;

  tvs_weights u_weights (
    .clk       (clk),
    .rst_n     (rst_n),
    .frac_x    (frac_x_r),
    .frac_y    (frac_y_r),
    .frac_z    (frac_z_r),
    .weights_r (weights)
  );

  // sample point and per-bank neighbor addresses
  logic [6:0]         sx, sy;
  logic [5:0]         sz;
  logic [6:0]         nbx, nby;
  logic [5:0]         nbz;
  logic [AW-1:0]      raddr [NCORNER];
  logic [NCORNER-1:0] oob;
  logic               wr_ok;
  logic [2:0]         wr_bank;
  logic [AW-1:0]      waddr;
  logic [NCORNER-1:0] bank_we;
  smp_ctl_t           ctl_r, ctl_nxt;

  always_comb begin
    sx = 7'(base_x_r) + 7'(in_item.out_col);
    sy = 7'(base_y_r) + 7'(in_item.out_row);
    sz = 6'(base_z_r);
    nbx = '0;
    nby = '0;
    nbz = '0;
    for (int b = 0; b < NCORNER; b++) begin
      // bank b holds whichever of the two neighbors has its parity
      nbx = sx + 7'(b % 2 != int'(sx[0]));
      nby = sy + 7'((b / 2) % 2 != int'(sy[0]));
      nbz = sz + 6'(b / 4 != int'(sz[0]));
      raddr[b] = bank_addr(int'(nbx[6:1]), int'(nby[6:1]), int'(nbz[5:1]));
      // corner b lies at offset b from the sample point
      oob[b] = !((int'(sx) + b % 2 < DIM_X) && (int'(sy) + (b / 2) % 2 < DIM_Y) &&
                 (int'(sz) + b / 4 < DIM_Z));
    end
    ctl_nxt.valid = accept && (in_item.cmd == CMD_SAMPLE);
    ctl_nxt.oob   = oob;
    ctl_nxt.par   = {sz[0], sy[0], sx[0]};
  end

  // voxel write goes straight into its parity bank
  always_comb begin
    wr_ok = accept && (in_item.cmd == CMD_WRITE) && (int'(in_item.vox_x) < DIM_X) &&
            (int'(in_item.vox_y) < DIM_Y) && (int'(in_item.vox_z) < DIM_Z);
    wr_bank = {in_item.vox_z[0], in_item.vox_y[0], in_item.vox_x[0]};
    waddr = bank_addr(int'(in_item.vox_x[5:1]), int'(in_item.vox_y[5:1]),
                      int'(in_item.vox_z[4:1]));
    for (int b = 0; b < NCORNER; b++) begin
      bank_we[b] = wr_ok && (wr_bank == 3'(b));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_nxt.valid;
    end
    ctl_r.oob <= ctl_nxt.oob;
    ctl_r.par <= ctl_nxt.par;
  end

  // eight parity banks; a write and a sample never share a cycle, and a
  // read in the cycle after a write to the same entry sees the new data
  logic [NCORNER-1:0][VOX_W-1:0] bank_rd;

  for (genvar g = 0; g < NCORNER; g++) begin : g_bank
    tvs_bank #(
      .DEPTH (BANK_DEPTH),
      .AW    (AW)
    ) u_bank (
      .clk     (clk),
      .we      (bank_we[g]),
      .waddr   (waddr),
      .wdata   (in_item.voxel_value),
      .raddr   (raddr[g]),
      .rdata_r (bank_rd[g])
    );
  end

  // corner select, weighting and the summing tree
  tvs_blend u_blend (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl_r),
    .bank_rd     (bank_rd),
    .weights     (weights),
    .out_valid_r (out_valid),
    .out_item_r  (out_item)
  );

  logic [3*FRAC_W-1:0] frac_all;
  assign frac_all = {frac_x_r, frac_y_r, frac_z_r};

  // a result beat traces back to an accepted sample command
  a_out_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept && (in_item.cmd == CMD_SAMPLE), 5))
    else $error("result beat without a matching sample");

  // a voxel write lands in at most one bank
  a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bank_we))
    else $error("voxel write hit more than one bank");

  // weights stay stable while the frac registers have not changed
  a_weights_follow_frac: assert property (@(posedge clk) disable iff (!rst_n)
    (($past(frac_all, 1) == $past(frac_all, 2)) &&
     ($past(frac_all, 2) == $past(frac_all, 3))) |-> $stable(weights))
    else $error("corner weights moved without a frac change");

endmodule

@@ rtl/core/tvs_bank.sv @@
module tvs_bank
  import tvs_pkg::*;
#(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [VOX_W-1:0] wdata,
  input  logic [AW-1:0]           raddr,
  output logic signed [VOX_W-1:0] rdata_r
);

  logic signed [VOX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ rtl/core/tvs_weights.sv @@
module tvs_weights
  import tvs_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [FRAC_W-1:0]                frac_x,
  input  logic [FRAC_W-1:0]                frac_y,
  input  logic [FRAC_W-1:0]                frac_z,
  output logic [NCORNER-1:0][WGT_W-1:0]    weights_r
);

  logic [1:0][WGT_W-1:0] wx, wy, wz;
  logic [3:0][WGT_W-1:0] wxy_r, wxy_nxt;
  logic [NCORNER-1:0][WGT_W-1:0] weights_nxt;

  always_comb begin
    wx[0] = Q_ONE - WGT_W'(frac_x);
    wx[1] = WGT_W'(frac_x);
    wy[0] = Q_ONE - WGT_W'(frac_y);
    wy[1] = WGT_W'(frac_y);
    wz[0] = Q_ONE - WGT_W'(frac_z);
    wz[1] = WGT_W'(frac_z);
    for (int i = 0; i < 4; i++) begin
      wxy_nxt[i] = mul_round(wx[i % 2], wy[i / 2]);
    end
    for (int k = 0; k < NCORNER; k++) begin
      weights_nxt[k] = mul_round(wxy_r[k % 4], wz[k / 4]);
    end
  end

  // reset values match zero fractions: corner 000 weighs one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wxy_r     <= {(3*WGT_W)'(0), Q_ONE};
      weights_r <= {((NCORNER-1)*WGT_W)'(0), Q_ONE};
    end else begin
      wxy_r     <= wxy_nxt;
      weights_r <= weights_nxt;
    end
  end

endmodule

@@ rtl/core/tvs_blend.sv @@
module tvs_blend
  import tvs_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst_n,
  input  smp_ctl_t                        ctl,
  input  logic [NCORNER-1:0][VOX_W-1:0]   bank_rd,
  input  logic [NCORNER-1:0][WGT_W-1:0]   weights,
  output logic                            out_valid_r,
  output out_item_t                       out_item_r
);

  // stage 1: corner data, stage 2: products, stage 3: half sums, stage 4: result
  logic signed [VOX_W-1:0] corner_r [NCORNER];
  logic signed [VOX_W-1:0] corner_nxt [NCORNER];
  logic signed [ACC_W-1:0] prod_r [NCORNER];
  logic signed [ACC_W-1:0] prod_nxt [NCORNER];
  logic signed [ACC_W-1:0] half_r [2];
  logic signed [ACC_W-1:0] half_nxt [2];
  logic signed [ACC_W-1:0] total;
  logic signed [ACC_W-1:0] shifted;
  logic signed [VOX_W+WGT_W:0] mult [NCORNER];
  logic [2:0] valid_r;
  logic [2:0] oov_r;
  out_item_t  out_item_nxt;

  always_comb begin
    for (int k = 0; k < NCORNER; k++) begin
      corner_nxt[k] = ctl.oob[k] ? '0 : $signed(bank_rd[3'(k) ^ ctl.par]);
      mult[k]       = corner_r[k] * $signed({1'b0, weights[k]});
      prod_nxt[k]   = ACC_W'(mult[k]);
    end
    half_nxt[0] = (prod_r[0] + prod_r[1]) + (prod_r[2] + prod_r[3]);
    half_nxt[1] = (prod_r[4] + prod_r[5]) + (prod_r[6] + prod_r[7]);
    total   = half_r[0] + half_r[1];
    shifted = total >>> FRAC_W;
    if (shifted > ACC_W'(VOX_MAX)) begin
      out_item_nxt.sample_value = VOX_MAX;
    end else if (shifted < ACC_W'(VOX_MIN)) begin
      out_item_nxt.sample_value = VOX_MIN;
    end else begin
      out_item_nxt.sample_value = shifted[VOX_W-1:0];
    end
    out_item_nxt.out_of_volume = oov_r[2];
  end

  always_ff @(posedge clk) begin
    corner_r   <= corner_nxt;
    prod_r     <= prod_nxt;
    half_r     <= half_nxt;
    out_item_r <= out_item_nxt;
    oov_r      <= {oov_r[1:0], |ctl.oob};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= {valid_r[1:0], ctl.valid};
      out_valid_r <= valid_r[2];
    end
  end

endmodule
